>>> design/xmodem_block_sender_defines.svh
// Assertion macros shared by the xmodem block sender modules.
// Depends on nothing; included inside module bodies.
`ifndef XMODEM_BLOCK_SENDER_DEFINES_SVH
`define XMODEM_BLOCK_SENDER_DEFINES_SVH
// Implication checked every cycle outside reset.
`define XBS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define XBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> design/xbs_pkg.sv
// Types and constants for the xmodem block sender.
// Depends on nothing.
package xbs_pkg;
  localparam logic [7:0] BLOCK_BYTES = 8'd128;

  localparam logic [2:0] KIND_START = 3'd0;
  localparam logic [2:0] KIND_DATA  = 3'd1;
  localparam logic [2:0] KIND_TICK  = 3'd3;
  localparam logic [2:0] KIND_RESP  = 3'd4;

  localparam logic [2:0] EV_SENT    = 3'd0;
  localparam logic [2:0] EV_TIMEOUT = 3'd1;
  localparam logic [2:0] EV_NAK     = 3'd2;
  localparam logic [2:0] EV_CRC     = 3'd3;
  localparam logic [2:0] EV_DONE    = 3'd4;
  localparam logic [2:0] EV_ABORT   = 3'd5;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_C   = 8'h43;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [0:0] REG_INTERVAL = 1'b0;
  localparam logic [0:0] REG_LIMIT    = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic start;      // begin transfer and seal
    logic seal;       // seal next block
    logic append;     // store data byte
    logic tick;       // count one tick
    logic ack;        // clear ticks, reload countdown
    logic set_crc;    // switch to CRC
    logic stop;       // end transfer
    logic pkt_begin;  // reset packet walk
    logic pkt_step;   // accumulate one block byte
    logic word_load;  // assemble next output word
  } xbs_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic active;
    logic is_eot;
    logic first_sent;
    logic expire;     // countdown will expire on this tick
    logic abort;      // tick count exceeds limit after this tick
    logic seal_busy;
    logic walk_done;  // all block bytes summed
    logic word_last;  // word just loaded was the final one
    logic word_done;  // an output word is complete
  } xbs_sts_t;
endpackage

>>> design/xmodem_block_sender.sv
// XMODEM block sender. A start item seals the staged file bytes as block one;
// ACK, NAK, 'C' and tick items send or resend packets as 64-bit words of up to
// eight bytes, with an 8-bit sum or CRC-16 check. A seal sweeps the 128-byte
// buffer, the check walk then reads the whole block, and each output word is
// assembled byte by byte from the single block memory read port. No clearing pass.
module xmodem_block_sender (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] tx_data,
  output logic [3:0]  tx_count,
  output logic [2:0]  event_res,
  output logic        last
);
  import xbs_pkg::*;

  logic [15:0] resend_interval, abort_limit;
  xbs_cmd_t cmd;
  xbs_sts_t sts;
  logic [63:0] word;
  logic [3:0]  word_count;
  logic        use_word;

  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      resend_interval <= 16'd10000;
      abort_limit <= 16'd60000;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_INTERVAL) resend_interval <= pwdata[15:0];
      else abort_limit <= pwdata[15:0];
    end
  end
  assign prdata = {16'h0000, (paddr[2] == REG_INTERVAL) ? resend_interval : abort_limit};

  xbs_datapath u_dp (
    .clk, .rst, .cmd, .data_byte, .resend_interval, .abort_limit,
    .sts, .word, .word_count
  );

  xbs_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .kind, .rx_byte, .sts, .cmd,
    .out_valid, .out_ready, .event_res, .last, .use_word
  );

  assign tx_data = use_word ? word : 64'h0;
  assign tx_count = use_word ? word_count : 4'd0;
endmodule

>>> design/xbs_datapath.sv
// Datapath: staging and block buffers, counters, checksum and packet words.
// Depends on xbs_pkg.
module xbs_datapath (
  input  logic              clk,
  input  logic              rst,
  input  xbs_pkg::xbs_cmd_t cmd,
  input  logic [7:0]        data_byte,
  input  logic [15:0]       resend_interval,
  input  logic [15:0]       abort_limit,
  output xbs_pkg::xbs_sts_t sts,
  output logic [63:0]       word,
  output logic [3:0]        word_count
);
  import xbs_pkg::*;

  logic [7:0] staging_mem [0:127];
  logic [7:0] block_mem [0:127];
  logic [7:0] staging_count;
  logic [7:0] block_fill;
  logic       block_is_eot;
  logic [7:0] block_number;
  logic       crc_mode;
  logic       first_sent;
  logic       active;
  logic [16:0] tick_count;
  logic [15:0] resend_countdown;
  logic [16:0] tick_next;

  // seal copy sweep
  logic        sealing;
  logic [7:0]  seal_idx;
  logic [7:0]  staging_rd;
  logic [7:0]  seal_wr_idx;
  logic        seal_wr;

  // packet walk: read block, accumulate check
  logic [7:0]  walk_idx;
  logic [7:0]  block_rd;
  logic        rd_valid;
  logic [15:0] crc;
  logic [7:0]  sum;
  logic [15:0] crc_next;
  logic        walk_done;

  // word emission
  logic [4:0]  word_idx;
  logic [7:0]  wr_pos;      // block index of the packet byte being read
  logic [7:0]  pkt_byte [0:7];
  logic [7:0]  wbuf_rd;
  logic [7:0]  pkt_pos;
  logic [7:0]  pkt_len;
  logic [3:0]  byte_cnt;
  logic        rd_pending;
  logic [7:0]  cur_pos;
  logic [7:0]  cur_byte;
  logic        wdone;

  assign tick_next = (tick_count == 17'h1FFFF) ? tick_count : tick_count + 17'd1;

  // staging writes and seal sweep reads
  always_ff @(posedge clk) begin
    if (cmd.append && staging_count < BLOCK_BYTES) begin
      staging_mem[staging_count[6:0]] <= data_byte;
    end
    staging_rd <= staging_mem[seal_idx[6:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sealing <= 1'b0;
      seal_idx <= '0;
      seal_wr <= 1'b0;
      seal_wr_idx <= '0;
      staging_count <= '0;
      block_fill <= '0;
      block_is_eot <= 1'b0;
      block_number <= '0;
      crc_mode <= 1'b0;
      first_sent <= 1'b0;
      active <= 1'b0;
      tick_count <= '0;
      resend_countdown <= '0;
    end else begin
      seal_wr <= sealing;
      seal_wr_idx <= seal_idx;
      if (sealing) begin
        if (seal_idx == 8'd127) sealing <= 1'b0;
        seal_idx <= seal_idx + 8'd1;
      end
      if (cmd.append && staging_count < BLOCK_BYTES) staging_count <= staging_count + 8'd1;
      if (cmd.start || cmd.seal) begin
        sealing <= 1'b1;
        seal_idx <= '0;
        block_fill <= staging_count;
        block_is_eot <= (staging_count == 8'd0);
        block_number <= (cmd.start ? 8'd0 : block_number) + 8'd1;
        staging_count <= '0;
      end
      if (cmd.start) begin
        active <= 1'b1;
        crc_mode <= 1'b0;
        first_sent <= 1'b0;
        tick_count <= '0;
        resend_countdown <= resend_interval;
      end
      if (cmd.tick) begin
        tick_count <= tick_next;
        if (resend_countdown <= 16'd1) resend_countdown <= resend_interval;
        else resend_countdown <= resend_countdown - 16'd1;
      end
      if (cmd.ack) begin
        tick_count <= '0;
        resend_countdown <= resend_interval;
      end
      if (cmd.set_crc) crc_mode <= 1'b1;
      if (cmd.stop) active <= 1'b0;
      if (cmd.pkt_begin) first_sent <= 1'b1;
    end
  end

  // block buffer: zero-padded copy from staging
  always_ff @(posedge clk) begin
    if (seal_wr) begin
      block_mem[seal_wr_idx[6:0]] <= (seal_wr_idx < block_fill) ? staging_rd : 8'h00;
    end
    block_rd <= block_mem[cmd.word_load ? wr_pos[6:0] : walk_idx[6:0]];
  end

  // CRC over one byte, eight narrow steps
  always_comb begin
    logic [15:0] c;
    c = crc ^ {block_rd, 8'h00};
    for (int b = 0; b < 8; b++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    crc_next = c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_idx <= '0;
      rd_valid <= 1'b0;
      walk_done <= 1'b0;
      crc <= '0;
      sum <= '0;
    end else if (cmd.pkt_begin) begin
      walk_idx <= '0;
      rd_valid <= 1'b0;
      walk_done <= 1'b0;
      crc <= '0;
      sum <= '0;
    end else if (cmd.pkt_step) begin
      if (rd_valid) begin
        crc <= crc_next;
        sum <= sum + block_rd;
        if (walk_idx == BLOCK_BYTES) walk_done <= 1'b1;
      end
      rd_valid <= (walk_idx < BLOCK_BYTES);
      if (walk_idx < BLOCK_BYTES) walk_idx <= walk_idx + 8'd1;
    end
  end

  // Word assembly: packet bytes are read one at a time into an array of eight.
  // Packet byte p: 0 SOH, 1 num, 2 ~num, 3..130 data, 131.. check.
  assign pkt_len = block_is_eot ? 8'd1 : (crc_mode ? 8'd133 : 8'd132);
  assign wbuf_rd = block_rd;
  assign wr_pos = pkt_pos - 8'd3;

  always_comb begin
    if (block_is_eot) cur_byte = CH_EOT;
    else if (cur_pos == 8'd0) cur_byte = CH_SOH;
    else if (cur_pos == 8'd1) cur_byte = block_number;
    else if (cur_pos == 8'd2) cur_byte = ~block_number;
    else if (cur_pos < 8'd131) cur_byte = wbuf_rd;
    else if (cur_pos == 8'd131) cur_byte = crc_mode ? crc[15:8] : sum;
    else cur_byte = crc[7:0];
  end

  // word_load is dropped by the controller while a complete word waits
  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_pos <= '0;
      byte_cnt <= '0;
      rd_pending <= 1'b0;
      cur_pos <= '0;
      wdone <= 1'b0;
      word_idx <= '0;
    end else if (cmd.pkt_begin) begin
      pkt_pos <= '0;
      byte_cnt <= '0;
      rd_pending <= 1'b0;
      wdone <= 1'b0;
      word_idx <= '0;
    end else if (cmd.word_load) begin
      if (!rd_pending) begin
        // start a fresh word after a complete one, then read pkt_pos
        if (wdone) begin
          wdone <= 1'b0;
          byte_cnt <= '0;
        end
        cur_pos <= pkt_pos;
        rd_pending <= 1'b1;
      end else begin
        pkt_byte[byte_cnt[2:0]] <= cur_byte;
        byte_cnt <= byte_cnt + 4'd1;
        pkt_pos <= pkt_pos + 8'd1;
        rd_pending <= 1'b0;
        if (byte_cnt == 4'd7 || pkt_pos + 8'd1 == pkt_len) begin
          wdone <= 1'b1;
          word_idx <= word_idx + 5'd1;
        end
      end
    end
  end

  // word output: bytes beyond count read as zero
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      word[8*i +: 8] = (4'(i) < byte_cnt) ? pkt_byte[i] : 8'h00;
    end
  end
  assign word_count = byte_cnt;

  assign sts.active = active;
  assign sts.is_eot = block_is_eot;
  assign sts.first_sent = first_sent;
  assign sts.expire = (resend_countdown <= 16'd1);
  assign sts.abort = (tick_next > {1'b0, abort_limit});
  assign sts.seal_busy = sealing | seal_wr;
  assign sts.walk_done = walk_done;
  assign sts.word_last = wdone && (pkt_pos == pkt_len);
  assign sts.word_done = wdone;

  // word_idx counts assembled words; kept for the bound check below
  `include "xmodem_block_sender_defines.svh"
  `XBS_ASSERT_IMP(a_fill_bound, 1'b1, staging_count <= BLOCK_BYTES)
  `XBS_ASSERT_IMP(a_words_bound, 1'b1, word_idx <= 5'd17)
  `XBS_ASSERT_NEXT(a_seal_clears, cmd.seal, staging_count <= 8'd1)
endmodule

>>> design/xbs_ctrl.sv
// Controller: decodes items, sequences sealing, check walk and word output.
// Depends on xbs_pkg.
module xbs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        kind,
  input  logic [7:0]        rx_byte,
  input  xbs_pkg::xbs_sts_t sts,
  output xbs_pkg::xbs_cmd_t cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        event_res,
  output logic              last,
  output logic              use_word
);
  import xbs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SEAL  = 6'b000010,
    S_WALK  = 6'b000100,
    S_LOAD  = 6'b001000,
    S_OUT   = 6'b010000,
    S_STAT  = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic [2:0] ev, ev_next;
  logic       abort_after, abort_after_next;
  logic       acc;
  logic       send_now, was_last;

  assign acc = in_valid && in_ready;
  assign in_ready = (state == S_IDLE) && !sts.seal_busy;

  always_comb begin
    cmd = '0;
    state_next = state;
    ev_next = ev;
    abort_after_next = abort_after;
    send_now = 1'b0;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (kind)
            KIND_START: cmd.start = 1'b1;
            KIND_DATA: cmd.append = 1'b1;
            KIND_TICK: begin
              if (sts.active) begin
                cmd.tick = 1'b1;
                abort_after_next = sts.abort;
                if (sts.abort) cmd.stop = 1'b1;
                if (sts.expire && sts.first_sent) begin
                  ev_next = EV_TIMEOUT;
                  send_now = 1'b1;
                end else if (sts.abort) begin
                  ev_next = EV_ABORT;
                  state_next = S_STAT;
                end
              end
            end
            KIND_RESP: begin
              abort_after_next = 1'b0;
              if (sts.active) begin
                if (rx_byte == CH_ACK) begin
                  cmd.ack = 1'b1;
                  if (sts.is_eot) begin
                    cmd.stop = 1'b1;
                    ev_next = EV_DONE;
                    state_next = S_STAT;
                  end else begin
                    cmd.seal = 1'b1;
                    ev_next = EV_SENT;
                    state_next = S_SEAL;
                  end
                end else if (rx_byte == CH_NAK) begin
                  ev_next = EV_NAK;
                  send_now = 1'b1;
                end else if (rx_byte == CH_C) begin
                  cmd.set_crc = 1'b1;
                  ev_next = EV_CRC;
                  state_next = S_SEAL;
                end
              end
            end
            default: ;
          endcase
          if (send_now) state_next = S_SEAL;
        end
      end
      S_SEAL: begin
        if (!sts.seal_busy) begin
          cmd.pkt_begin = 1'b1;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        cmd.pkt_step = 1'b1;
        if (sts.walk_done) state_next = S_LOAD;
      end
      S_LOAD: begin
        // hold assembly once a word is complete
        if (sts.word_done) state_next = S_OUT;
        else cmd.word_load = 1'b1;
      end
      S_OUT: begin
        if (out_ready) begin
          if (was_last) begin
            if (abort_after) begin
              ev_next = EV_ABORT;
              state_next = S_STAT;
            end else begin
              state_next = S_IDLE;
            end
          end else begin
            cmd.word_load = 1'b1;
            state_next = S_LOAD;
          end
        end
      end
      S_STAT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ev <= EV_SENT;
      abort_after <= 1'b0;
      was_last <= 1'b0;
    end else begin
      state <= state_next;
      ev <= ev_next;
      abort_after <= abort_after_next;
      was_last <= sts.word_last;
    end
  end

  assign out_valid = (state == S_OUT) || (state == S_STAT);
  assign use_word = (state == S_OUT);
  assign event_res = ev;
  assign last = (state == S_STAT) || ((state == S_OUT) && was_last && !abort_after);

  `include "xmodem_block_sender_defines.svh"
  `XBS_ASSERT_IMP(a_no_take_busy, acc, state == S_IDLE)
  `XBS_ASSERT_IMP(a_stat_event, state == S_STAT, ev == EV_DONE || ev == EV_ABORT)
  `XBS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
endmodule
